// ----- sv/nearest_centroid_assign_top_macros.svh -----
// Assertion macros for the nearest-centroid assignment block.
// Expects signals clk and rst in the scope of each use.
`ifndef NEAREST_CENTROID_ASSIGN_TOP_MACROS_SVH
`define NEAREST_CENTROID_ASSIGN_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define NCA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NCA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/nca_pkg.sv -----
// Shared constants and controller/datapath interface types for the
// nearest-centroid assignment block. No dependencies.
package nca_pkg;

  localparam int MAX_CLUSTERS = 8;
  localparam int MAX_DIMS     = 16;
  localparam int COORD_BITS   = 16;
  localparam int CLUSTER_BITS = 3;
  localparam int DIM_BITS     = 4;
  localparam int CFG_BITS     = 4;
  localparam int ACC_BITS     = 36;
  localparam int SQ_BITS      = 2 * COORD_BITS;
  localparam int TABLE_DEPTH  = MAX_CLUSTERS * MAX_DIMS;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // input item accepted this cycle
    logic k_clear;
    logic k_inc;
    logic mul;      // square the difference to centroid k
    logic acc;      // add the square into accumulator k
    logic srch;     // compare accumulator k against the running minimum
    logic emit;     // load the result register and clear the accumulators
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_kind;  // kind field of the item on offer
    logic pt_last;  // captured point coordinate is the last one
    logic k_last;   // centroid counter is at the last active centroid
    logic out_busy; // result register full and not taken this cycle
  } sts_t;

endpackage

// ----- sv/nca_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module nca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  localparam int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/nca_ctrl.sv -----
// Sequencing state machine for the nearest-centroid assignment block.
// Depends on nca_pkg for the command and status types.
module nca_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  nca_pkg::sts_t sts,
  output nca_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_MUL,
    S_ACC,
    S_SRCH,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (sts.in_kind) begin
            cmd.k_clear = 1'b1;
            state_next  = S_RD;
          end
        end
      end
      S_RD: begin
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (sts.k_last) begin
          cmd.k_clear = 1'b1;
          state_next  = sts.pt_last ? S_SRCH : S_IDLE;
        end else begin
          cmd.k_inc  = 1'b1;
          state_next = S_RD;
        end
      end
      S_SRCH: begin
        cmd.srch = 1'b1;
        if (sts.k_last) begin
          state_next = S_EMIT;
        end else begin
          cmd.k_inc = 1'b1;
        end
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- sv/nca_dp.sv -----
// Datapath: configuration register, centroid table, squaring unit,
// accumulators, minimum search and result register. Uses nca_pkg and nca_ram.
module nca_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [nca_pkg::CFG_BITS-1:0]          cfg_data,
  input  logic                                  kind,
  input  logic [nca_pkg::CLUSTER_BITS-1:0]      centroid_index,
  input  logic [nca_pkg::DIM_BITS-1:0]          coord_index,
  input  logic signed [nca_pkg::COORD_BITS-1:0] coord_value,
  input  logic                                  point_last,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [nca_pkg::CLUSTER_BITS-1:0]      best_cluster,
  output logic [nca_pkg::ACC_BITS-1:0]          min_distance_sq,
  input  nca_pkg::cmd_t                         cmd,
  output nca_pkg::sts_t                         sts
);

  localparam int ADDR_BITS = nca_pkg::CLUSTER_BITS + nca_pkg::DIM_BITS;

  logic [nca_pkg::CFG_BITS-1:0]          num_clusters;
  logic [nca_pkg::CFG_BITS-1:0]          active;
  logic [nca_pkg::DIM_BITS-1:0]          pt_didx;
  logic signed [nca_pkg::COORD_BITS-1:0] pt_val;
  logic                                  pt_last;
  logic [nca_pkg::CLUSTER_BITS-1:0]      k;
  logic [nca_pkg::COORD_BITS-1:0]        cent_raw;
  logic signed [nca_pkg::COORD_BITS:0]   diff;
  logic [nca_pkg::COORD_BITS:0]          mag;
  logic [nca_pkg::SQ_BITS-1:0]           sq;
  logic [nca_pkg::ACC_BITS-1:0]          acc [nca_pkg::MAX_CLUSTERS];
  logic [nca_pkg::ACC_BITS-1:0]          acc_k;
  logic [nca_pkg::ACC_BITS:0]            acc_sum;
  logic [nca_pkg::ACC_BITS-1:0]          best_d;
  logic [nca_pkg::CLUSTER_BITS-1:0]      best_idx;

  // Count of centroids in use: zero acts as one, too large acts as the maximum.
  always_comb begin
    if (num_clusters == '0) begin
      active = nca_pkg::CFG_BITS'(1);
    end else if (num_clusters > nca_pkg::CFG_BITS'(nca_pkg::MAX_CLUSTERS)) begin
      active = nca_pkg::CFG_BITS'(nca_pkg::MAX_CLUSTERS);
    end else begin
      active = num_clusters;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_clusters <= nca_pkg::CFG_BITS'(1);
    end else if (cfg_write) begin
      num_clusters <= cfg_data;
    end
  end

  nca_ram #(
    .WIDTH (nca_pkg::COORD_BITS),
    .DEPTH (nca_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (cmd.capture && !kind),
    .waddr ({centroid_index, coord_index}),
    .wdata (coord_value),
    .raddr (ADDR_BITS'({k, pt_didx})),
    .rdata (cent_raw)
  );

  // Difference to the stored centroid coordinate and its magnitude.
  assign diff = {pt_val[nca_pkg::COORD_BITS-1], pt_val}
              - {cent_raw[nca_pkg::COORD_BITS-1], cent_raw};
  assign mag  = diff[nca_pkg::COORD_BITS] ? (~diff + 1'b1) : diff;

  assign acc_k   = acc[k];
  assign acc_sum = {1'b0, acc_k} + (nca_pkg::ACC_BITS + 1)'(sq);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pt_didx <= coord_index;
      pt_val  <= coord_value;
      pt_last <= point_last;
    end
    if (cmd.mul) begin
      sq <= mag[nca_pkg::COORD_BITS-1:0] * mag[nca_pkg::COORD_BITS-1:0];
    end
    if (cmd.srch) begin
      if (k == '0 || acc_k < best_d) begin
        best_d   <= acc_k;
        best_idx <= k;
      end
    end
    if (cmd.emit) begin
      best_cluster    <= best_idx;
      min_distance_sq <= best_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k         <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < nca_pkg::MAX_CLUSTERS; i++) begin
        acc[i] <= '0;
      end
    end else begin
      if (cmd.k_clear) begin
        k <= '0;
      end else if (cmd.k_inc) begin
        k <= k + 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.emit) begin
        for (int i = 0; i < nca_pkg::MAX_CLUSTERS; i++) begin
          acc[i] <= '0;
        end
      end else if (cmd.acc) begin
        acc[k] <= acc_sum[nca_pkg::ACC_BITS] ? '1 : acc_sum[nca_pkg::ACC_BITS-1:0];
      end
    end
  end

  assign sts.in_kind  = kind;
  assign sts.pt_last  = pt_last;
  assign sts.k_last   = (k == nca_pkg::CLUSTER_BITS'(active - 1'b1));
  assign sts.out_busy = out_valid && !out_ready;

endmodule

// ----- sv/nearest_centroid_assign_top.sv -----
// Nearest-centroid assignment (k-means assignment step); uses nca_pkg, nca_ctrl, nca_dp.
// A load item only writes the table and the block is ready again at once. A point
// coordinate steps each active centroid through S_RD, S_MUL and S_ACC in turn (one table
// read port and one squaring unit); a last coordinate then scans the accumulators in S_SRCH
// and loads the result register in S_EMIT, which waits while the previous result is still held.
// Synchronous reset: accumulators cleared, cluster count 1, table left unwritten.
`include "nearest_centroid_assign_top_macros.svh"

module nearest_centroid_assign_top (
  input  logic                                  clk,
  input  logic                                  rst,
  // Configuration: number of centroids in use.
  input  logic                                  cfg_write,
  input  logic [nca_pkg::CFG_BITS-1:0]          cfg_data,
  // Input items.
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  kind,
  input  logic [nca_pkg::CLUSTER_BITS-1:0]      centroid_index,
  input  logic [nca_pkg::DIM_BITS-1:0]          coord_index,
  input  logic signed [nca_pkg::COORD_BITS-1:0] coord_value,
  input  logic                                  point_last,
  // Result items.
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [nca_pkg::CLUSTER_BITS-1:0]      best_cluster,
  output logic [nca_pkg::ACC_BITS-1:0]          min_distance_sq
);

  // The controller steps through the active centroids one at a time for each
  // point coordinate, then, on the last coordinate, scans the accumulators for
  // the minimum. The datapath holds the centroid table, the accumulators and
  // the result register, so a finished result can wait while the next item
  // is already being taken in.
  nca_pkg::cmd_t cmd;
  nca_pkg::sts_t sts;

  nca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nca_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .kind            (kind),
    .centroid_index  (centroid_index),
    .coord_index     (coord_index),
    .coord_value     (coord_value),
    .point_last      (point_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .best_cluster    (best_cluster),
    .min_distance_sq (min_distance_sq),
    .cmd             (cmd),
    .sts             (sts)
  );

  // A point item starts the centroid sweep, so the input side must close.
  `NCA_ASSERT_NEXT(a_point_busy, in_valid && in_ready && kind, !in_ready, "ready after point item")
  // A new result is only loaded when the result register is free.
  `NCA_ASSERT_NOW(a_emit_free, cmd.emit, !sts.out_busy, "result register overwritten")
  // Only the last coordinate of a point produces a result.
  `NCA_ASSERT_NOW(a_emit_last, cmd.emit, sts.pt_last, "result without last coordinate")
  // Loading the result register always presents a result next cycle.
  `NCA_ASSERT_NEXT(a_emit_shown, cmd.emit, out_valid, "loaded result not presented")

endmodule
